// File: hw/rtl/bdq_pkg.sv
// Shared types and constants of the bounded deque with indexed read.
package bdq_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int OCC_W = 9;
    localparam int OP_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_COUNT      = 3'd5,
        OP_CLEAR      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic                    push_front;
        logic                    pop_front;
        logic                    push_back;
        logic                    scan_load;
        logic                    scan_shift;
        logic signed [VAL_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [OCC_W-1:0]        occupancy;
        status_t                 status;
    } result_t;

endpackage

// File: hw/rtl/bdq_if.sv
// Valid/ready channel interfaces for requests and results of the deque.
interface bdq_req_if;
    logic                               valid;
    logic                               ready;
    logic [bdq_pkg::OP_W-1:0]           operation;
    logic signed [bdq_pkg::VAL_W-1:0]   value;
    logic [bdq_pkg::POS_W-1:0]          position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface bdq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [bdq_pkg::VAL_W-1:0]   read_value;
    logic [bdq_pkg::OCC_W-1:0]          occupancy;
    logic [1:0]                         status;

    modport source (output valid, output read_value, output occupancy, output status,
                    input ready);
    modport sink   (input valid, input read_value, input occupancy, input status,
                    output ready);
endinterface

// File: hw/rtl/bdq_cell.sv
// One cell of the deque chain: an element word and a scan word.
module bdq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                                clk,
    input  bdq_pkg::cell_ctrl_t                 ctrl,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [bdq_pkg::VAL_W-1:0]    left_data,
    input  logic signed [bdq_pkg::VAL_W-1:0]    right_data,
    input  logic signed [bdq_pkg::VAL_W-1:0]    right_scan,
    output logic signed [bdq_pkg::VAL_W-1:0]    data,
    output logic signed [bdq_pkg::VAL_W-1:0]    scan
);

    logic signed [bdq_pkg::VAL_W-1:0] data_reg;
    logic signed [bdq_pkg::VAL_W-1:0] scan_reg;
    logic                             tail_hit;

    // This cell is the first free slot behind the last element.
    assign tail_hit = (count == CNT_W'(IDX));

    always_ff @(posedge clk)
    begin
        if (ctrl.push_front)
        begin
            data_reg <= left_data;
        end
        else if (ctrl.pop_front)
        begin
            data_reg <= right_data;
        end
        else if (ctrl.push_back && tail_hit)
        begin
            data_reg <= ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_load)
        begin
            scan_reg <= data_reg;
        end
        else if (ctrl.scan_shift)
        begin
            scan_reg <= right_scan;
        end
    end

    assign data = data_reg;
    assign scan = scan_reg;

endmodule

// File: hw/rtl/bdq_result_fifo.sv
// Two-entry result queue that decouples the chain from the result channel.
module bdq_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bdq_pkg::result_t    push_data,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output bdq_pkg::result_t    out_data
);

    bdq_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (fill_reg != 2'd0);
    assign has_room  = (fill_reg != 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A result is only written when a slot is free.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fill_reg != 2'd2))
        else $error("result queue written while full");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("result queue fill count out of range");

    // A result that the receiver holds off stays offered and unchanged.
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

endmodule

// File: hw/rtl/bounded_deque_with_indexed_read.sv
// Top level of the bounded double-ended queue with indexed read.
//
// Requests arrive on the req channel (operation, value, position) and every
// request produces exactly one result item on the rsp channel (read_value,
// occupancy, status). The elements live in a chain of DEPTH cells: cell 0
// always holds the front element. Push front shifts the whole chain one cell
// toward the back, pop front shifts it one cell toward the front, push back
// writes the cell whose index equals the count, and pop back and clear only
// change the count.
// Push, pop, count, clear and every read that fails finish in the cycle they
// are accepted; the result can be taken in the next cycle and a new item can
// be accepted in every cycle while the result queue has room. A successful
// read at position p loads every cell's scan word and then shifts the scan
// words toward cell 0 once a cycle; its result is queued once the word from
// position p reaches cell 0, and no new item is accepted until the scan ends.
// Results pass through a two-entry queue, so one finished result may wait on
// a stalled receiver while the next item is still accepted; when both
// entries are full, req.ready drops until rsp takes an item.
// Reset empties the deque and the result queue; element words are not
// cleared and are never read before they are written.
module bounded_deque_with_indexed_read #(
    parameter int DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    bdq_req_if.sink         req,
    bdq_rsp_if.source       rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W;

    // Control state.
    bdq_pkg::state_t               state_reg;
    bdq_pkg::state_t               state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [bdq_pkg::POS_W-1:0]     remain_reg;
    logic [bdq_pkg::POS_W-1:0]     remain_next;

    // Request decode.
    bdq_pkg::op_t                  op;
    logic                          accept;
    logic                          full;
    logic                          empty;
    logic                          start_scan;
    logic                          scan_done;
    logic [CNT_W-1:0]              count_upd;
    logic signed [bdq_pkg::VAL_W-1:0] rd_value;
    bdq_pkg::status_t              rd_status;
    logic                          do_push_front;
    logic                          do_pop_front;
    logic                          do_push_back;

    // Chain and result queue.
    bdq_pkg::cell_ctrl_t           ctrl;
    logic signed [bdq_pkg::VAL_W-1:0] cell_data [DEPTH];
    logic signed [bdq_pkg::VAL_W-1:0] cell_scan [DEPTH];
    logic                          fifo_room;
    logic                          fifo_push;
    bdq_pkg::result_t              fifo_in;
    bdq_pkg::result_t              fifo_out;

    assign op     = bdq_pkg::op_t'(req.operation);
    assign accept = req.valid && req.ready;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign scan_done = (state_reg == bdq_pkg::S_SCAN) && (remain_reg == '0);

    // Effect of the request on the count and the immediate result fields.
    always_comb
    begin
        count_upd     = count_reg;
        rd_value      = '0;
        rd_status     = bdq_pkg::ST_OK;
        do_push_front = 1'b0;
        do_pop_front  = 1'b0;
        do_push_back  = 1'b0;
        start_scan    = 1'b0;
        case (op)
            bdq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    rd_status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    do_push_front = 1'b1;
                    count_upd     = count_reg + CNT_W'(1);
                end
            end
            bdq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    rd_status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    do_push_back = 1'b1;
                    count_upd    = count_reg + CNT_W'(1);
                end
            end
            bdq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    rd_status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    do_pop_front = 1'b1;
                    count_upd    = count_reg - CNT_W'(1);
                end
            end
            bdq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    rd_status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_upd = count_reg - CNT_W'(1);
                end
            end
            bdq_pkg::OP_READ:
            begin
                if (empty)
                begin
                    rd_status = bdq_pkg::ST_EMPTY;
                end
                else if (CMP_W'(req.position) >= CMP_W'(count_reg))
                begin
                    rd_value  = '1;
                    rd_status = bdq_pkg::ST_RANGE;
                end
                else
                begin
                    start_scan = 1'b1;
                end
            end
            bdq_pkg::OP_COUNT:
            begin
                count_upd = count_reg;
            end
            bdq_pkg::OP_CLEAR:
            begin
                if (empty)
                begin
                    rd_status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_upd = '0;
                end
            end
            default:
            begin
                count_upd = count_reg;
            end
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_upd;
                    if (start_scan)
                    begin
                        state_next  = bdq_pkg::S_SCAN;
                        remain_next = req.position;
                    end
                end
            end
            bdq_pkg::S_SCAN:
            begin
                if (remain_reg == '0)
                begin
                    state_next = bdq_pkg::S_IDLE;
                end
                else
                begin
                    remain_next = remain_reg - bdq_pkg::POS_W'(1);
                end
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, chain commands and results.
    always_comb
    begin
        req.ready       = (state_reg == bdq_pkg::S_IDLE) && fifo_room;
        ctrl.push_front = accept && do_push_front;
        ctrl.pop_front  = accept && do_pop_front;
        ctrl.push_back  = accept && do_push_back;
        ctrl.scan_load  = accept && start_scan;
        ctrl.scan_shift = (state_reg == bdq_pkg::S_SCAN) && (remain_reg != '0);
        ctrl.value      = req.value;
        if (scan_done)
        begin
            fifo_push          = 1'b1;
            fifo_in.read_value = cell_scan[0];
            fifo_in.occupancy  = bdq_pkg::OCC_W'(count_reg);
            fifo_in.status     = bdq_pkg::ST_OK;
        end
        else
        begin
            fifo_push          = accept && !start_scan;
            fifo_in.read_value = rd_value;
            fifo_in.occupancy  = bdq_pkg::OCC_W'(count_upd);
            fifo_in.status     = rd_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bdq_pkg::S_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    // The chain of cells. Cell 0 takes the pushed word on a push front; the
    // last cell sees zeros beyond the end of the chain.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [bdq_pkg::VAL_W-1:0] left_d;
        logic signed [bdq_pkg::VAL_W-1:0] right_d;
        logic signed [bdq_pkg::VAL_W-1:0] right_s;

        if (i == 0)
        begin : g_head
            assign left_d = req.value;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
            assign right_s = '0;
        end
        else
        begin : g_body
            assign right_d = cell_data[i+1];
            assign right_s = cell_scan[i+1];
        end

        bdq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .right_scan (right_s),
            .data       (cell_data[i]),
            .scan       (cell_scan[i])
        );
    end

    bdq_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_in),
        .has_room  (fifo_room),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (fifo_out)
    );

    assign rsp.read_value = fifo_out.read_value;
    assign rsp.occupancy  = fifo_out.occupancy;
    assign rsp.status     = fifo_out.status;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // No request is taken while a read scan is running.
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdq_pkg::S_SCAN) |-> !req.ready)
        else $error("request accepted during scan");

    // A scan always targets an element that is held.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdq_pkg::S_SCAN) |-> (CMP_W'(remain_reg) < CMP_W'(count_reg)))
        else $error("scan position beyond count");

    // A clear that finds elements leaves the deque empty.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == bdq_pkg::OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear left elements behind");

endmodule

// File: tb/bounded_deque_with_indexed_read_tb.sv
// Self-checking testbench for the bounded deque with indexed read.
module bounded_deque_with_indexed_read_tb;

    import bdq_pkg::*;

    // Depth of the deque under test and the code that no operation uses.
    localparam int                DEPTH     = 256;
    localparam logic [OP_W-1:0]   OP_UNUSED = 3'd7;

    // Shapes of the random stimulus: a growing phase pushes far more than it
    // pops, a shrinking phase does the opposite, and a mixed phase does a bit
    // of everything.
    localparam int MODE_GROW   = 0;
    localparam int MODE_MIXED  = 1;
    localparam int MODE_SHRINK = 2;

    localparam int RANDOM_ITEMS = 1700;

    // A successful read at the deepest position scans the whole chain, so
    // this many quiet cycles at the end leave room for any stray result.
    localparam int SETTLE_CYCLES = DEPTH + 50;

    // Shadow deque and the queue of results that it predicts. Each accepted
    // request updates the shadow state at once and queues exactly one result.
    class deque_scoreboard;
        logic signed [VAL_W-1:0] ring [DEPTH];
        logic [POS_W-1:0]        head;
        int unsigned             fill;
        result_t                 expected_q[$];
        int unsigned             requests;
        int unsigned             checked;
        int unsigned             errors;
        int unsigned             full_drops;
        int unsigned             empty_hits;
        int unsigned             range_hits;
        int unsigned             good_reads;
        int unsigned             peak_fill;

        function new();
            head       = '0;
            fill       = 0;
            requests   = 0;
            checked    = 0;
            errors     = 0;
            full_drops = 0;
            empty_hits = 0;
            range_hits = 0;
            good_reads = 0;
            peak_fill  = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                                   logic [POS_W-1:0] p);
            result_t          r;
            logic [POS_W-1:0] slot;
            r.read_value = '0;
            r.status     = ST_OK;
            requests++;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (fill >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        full_drops++;
                    end
                    else if (op == OP_PUSH_FRONT)
                    begin
                        head       = head - 1'b1;
                        ring[head] = v;
                        fill++;
                    end
                    else
                    begin
                        slot       = head + POS_W'(fill);
                        ring[slot] = v;
                        fill++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK, OP_CLEAR:
                begin
                    if (fill == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_hits++;
                    end
                    else if (op == OP_POP_FRONT)
                    begin
                        head = head + 1'b1;
                        fill--;
                    end
                    else if (op == OP_POP_BACK)
                        fill--;
                    else
                    begin
                        fill = 0;
                        head = '0;
                    end
                end
                OP_READ:
                begin
                    if (fill == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_hits++;
                    end
                    else if (p >= fill)
                    begin
                        r.read_value = -1;
                        r.status     = ST_RANGE;
                        range_hits++;
                    end
                    else
                    begin
                        slot         = head + p;
                        r.read_value = ring[slot];
                        good_reads++;
                    end
                end
                default: ;  // Count and the unused code leave the deque alone.
            endcase
            r.occupancy = OCC_W'(fill);
            if (fill > peak_fill)
                peak_fill = fill;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [VAL_W-1:0] rv, logic [OCC_W-1:0] occ,
                                   logic [1:0] st);
            result_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result %0d: value %0d occupancy %0d status %0d",
                             checked, rv, occ, st);
                return;
            end
            e = expected_q.pop_front();
            if (rv !== e.read_value || occ !== e.occupancy || st !== e.status)
            begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch on result %0d: expected value %0d occupancy %0d ",
                              "status %0d, got value %0d occupancy %0d status %0d"},
                             checked, e.read_value, e.occupancy, e.status, rv, occ, st);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    deque_scoreboard sb = new();

    // Set by the request side while it runs a stretch with no idle cycles; the
    // result side keeps ready high for the same stretch.
    bit no_idle;
    bit long_hold_done;

    bounded_deque_with_indexed_read #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offers one request and returns at the clock edge that accepts it. About
    // one request in six is preceded by a few idle cycles with valid low.
    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
                                input logic [POS_W-1:0] p);
        if (!no_idle && $urandom_range(99) < 18)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= v;
        req_ch.position  <= p;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, v, p);
    endtask

    // Stops offering requests until every predicted result has come back.
    // At least one edge passes with valid low, so a request that follows
    // never raises valid in the same step that lowered it.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Picks one request in the style of the current phase. Values are mostly
    // random words with the extremes mixed in; read positions mostly land
    // near the front to keep the scan short, sometimes anywhere in the deque,
    // and sometimes at or past the count.
    task automatic issue_random(input int mode);
        int unsigned             roll;
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] v;
        logic [POS_W-1:0]        p;
        roll = $urandom_range(99);
        case (mode)
            MODE_GROW:
                op = roll < 40 ? OP_PUSH_FRONT : roll < 80 ? OP_PUSH_BACK :
                     roll < 87 ? OP_READ : roll < 91 ? OP_POP_FRONT :
                     roll < 95 ? OP_POP_BACK : roll < 98 ? OP_COUNT : OP_UNUSED;
            MODE_SHRINK:
                op = roll < 35 ? OP_POP_FRONT : roll < 70 ? OP_POP_BACK :
                     roll < 80 ? OP_READ : roll < 84 ? OP_PUSH_FRONT :
                     roll < 88 ? OP_PUSH_BACK : roll < 93 ? OP_COUNT :
                     roll < 96 ? OP_UNUSED : OP_CLEAR;
            default:
                op = roll < 18 ? OP_PUSH_FRONT : roll < 36 ? OP_PUSH_BACK :
                     roll < 50 ? OP_POP_FRONT : roll < 64 ? OP_POP_BACK :
                     roll < 90 ? OP_READ : roll < 95 ? OP_COUNT :
                     roll < 99 ? OP_UNUSED : OP_CLEAR;
        endcase

        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(3))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = -1;
                default: v = 0;
            endcase
        end
        else
            v = $urandom;

        roll = $urandom_range(99);
        if (op != OP_READ || sb.fill == 0)
            p = POS_W'($urandom_range(255));
        else if (roll < 70)
            p = POS_W'($urandom_range(sb.fill > 16 ? 15 : sb.fill - 1));
        else if (roll < 85 || sb.fill == DEPTH)
            p = POS_W'($urandom_range(sb.fill - 1));
        else
            p = POS_W'($urandom_range(255, sb.fill));

        send_request(op, v, p);
    endtask

    // Every accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.read_value, rsp_ch.occupancy, rsp_ch.status);
    end

    // Result side. Ready is low about 18 percent of the time. Once, after 600
    // results, it is held low while requests keep coming, so the result queue
    // fills and the request side must stall.
    initial
    begin
        int unsigned held;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && sb.checked >= 600)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready   <= 1'b0;
                held = 0;
                while (held < 400)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            else if (no_idle)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 18);
        end
    end

    // Request side: reset, a directed opening, then phased random traffic.
    initial
    begin
        int unsigned sent;
        int unsigned block_len;
        int unsigned roll;
        int unsigned k;
        int          mode;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_COUNT;
        req_ch.value     <= '0;
        req_ch.position  <= '0;
        no_idle          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every operation but the pushes on the empty deque: pops and clear report empty,
        // reads report empty with a zero word whatever the position.
        send_request(OP_POP_FRONT, 0, 0);
        send_request(OP_POP_BACK, 0, 0);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 0, 8'd255);
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_COUNT, 0, 0);
        // The unused code with every value and position bit set does nothing.
        send_request(OP_UNUSED, -1, 8'd255);

        // Extreme words pushed at both ends: the deque then holds
        // -1, max, min, 0 from front to back.
        send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF, 0);
        send_request(OP_PUSH_BACK, 32'h8000_0000, 0);
        send_request(OP_PUSH_FRONT, -1, 0);
        send_request(OP_PUSH_BACK, 0, 0);

        // Reads at both ends, at exactly the count, and at the top position.
        send_request(OP_READ, 0, 8'd0);
        send_request(OP_READ, 0, 8'd3);
        send_request(OP_READ, 0, 8'd4);
        send_request(OP_READ, 0, 8'd255);

        send_request(OP_POP_FRONT, 0, 0);
        send_request(OP_POP_BACK, 0, 0);
        send_request(OP_COUNT, 0, 0);
        send_request(OP_READ, 0, 8'd1);
        send_request(OP_UNUSED, 0, 0);

        // Clear on a deque that holds words, then check that the ring starts
        // over from the front.
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_COUNT, 0, 0);
        send_request(OP_PUSH_BACK, 32'h1234_5678, 0);
        send_request(OP_READ, 0, 8'd0);

        drain_results();

        // The first phase grows long enough to fill the deque and push into
        // it while full; later phases are picked at random. A stretch in the
        // middle runs with no idle cycles on either side, and later on the
        // request side waits once until every result is back.
        sent      = 0;
        mode      = MODE_GROW;
        block_len = 420;
        while (sent < RANDOM_ITEMS)
        begin
            for (k = 0; k < block_len && sent < RANDOM_ITEMS; k++)
            begin
                no_idle = (sent >= 900 && sent < 1150);
                if (sent == 1300)
                    drain_results();
                issue_random(mode);
                sent++;
            end
            roll      = $urandom_range(99);
            mode      = roll < 45 ? MODE_GROW : roll < 75 ? MODE_MIXED : MODE_SHRINK;
            block_len = $urandom_range(320, 60);
        end
        no_idle = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d requests, peak occupancy %0d of %0d.",
                 sb.checked, sb.requests, sb.peak_fill, DEPTH);
        $display({"Saw %0d pushes dropped when full, %0d empty hits, ",
                  "%0d reads out of range, %0d good reads, %0d mismatches."},
                 sb.full_drops, sb.empty_hits, sb.range_hits, sb.good_reads, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case the block hangs; a correct run ends long before.
    initial
    begin
        #8_000_000;
        $display("Timeout with %0d results still expected.", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
